@@ rtl/lsfr_pkg.sv @@
// Package: shared types and constants for the load/store fault replay block.
`default_nettype none
package lsfr_pkg;
  localparam int unsigned SLOTS_DEF = 32;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_REG   = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_UNH   = 2'd3;

  // step operation codes issued by the decoder
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_MEMW1  = 3'd1,  // write first source at far
    OP_MEMW2  = 3'd2,  // write second source at far+ps
    OP_LD1    = 3'd3,  // load first value into rt
    OP_LD2    = 3'd4,  // load second value into rt2
    OP_WB     = 3'd5,  // base writeback
    OP_END    = 3'd6   // done / unhandled
  } step_op_t;

  typedef struct packed {
    logic     start;
    logic     slot_wr;
    logic     step;
    logic [1:0] idx;
  } lsfr_cmd_t;

  typedef struct packed {
    logic [2:0] nsteps;
    logic       is_last;
  } lsfr_sts_t;
endpackage
`default_nettype wire

@@ rtl/lsfr_dp.sv @@
// Datapath: context register file, instruction decode and result formation.
`default_nettype none
module lsfr_dp
  import lsfr_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire lsfr_cmd_t   cmd,
  input  wire logic [4:0]  in_slot_index,
  input  wire logic [63:0] in_slot_value,
  input  wire logic [10:0] in_vector_offset,
  input  wire logic [31:0] in_syndrome,
  input  wire logic [31:0] in_opcode,
  input  wire logic [63:0] in_instruction_address,
  input  wire logic [63:0] in_fault_address,
  input  wire logic [63:0] in_read_data_first,
  input  wire logic [63:0] in_read_data_second,
  input  wire logic        rst_n,
  output lsfr_sts_t        sts,
  output logic [1:0]       res_kind,
  output logic [63:0]      res_target,
  output logic [3:0]       res_size,
  output logic [63:0]      res_data
);
  logic [63:0] regs_r [SLOTS];
  logic [SLOTS-1:0] vld_r;

  logic [31:0] op_r;
  logic [63:0] ia_r, far_r, rd1_r, rd2_r;
  logic [63:0] st_src_r;
  logic        ok_r, wr_r;
  step_op_t    seq_r [4];
  logic [2:0]  nsteps_r;

  // decode of the incoming event, latched on start
  step_op_t    seq_nxt [4];
  logic [2:0]  n_nxt;
  logic [31:0] op;
  logic        ok;
  logic [31:0] m1, m2, mp;
  logic        ldp_plain, ldp_wb;

  function automatic logic [63:0] bmask(input logic [3:0] b);
    case (b)
      4'd1:    bmask = 64'hff;
      4'd2:    bmask = 64'hffff;
      4'd4:    bmask = 64'hffff_ffff;
      default: bmask = '1;
    endcase
  endfunction

  function automatic logic [63:0] sx32(input logic [63:0] v);
    sx32 = v[31] ? (v | 64'hffffffff00000000) : v;
  endfunction

  always_comb begin
    op = in_opcode;
    ok = (in_vector_offset[8:0] == 9'd0) && (in_syndrome[31:27] == 5'b10010);
    m1 = op & 32'h3fe00c00;
    m2 = op & 32'h7fc00000;
    mp = op & 32'hffc00000;
    ldp_plain = (op & 32'h7fc00000) == 32'h29400000;
    ldp_wb    = (op & 32'h7ec00000) == 32'h28c00000;
    for (int i = 0; i < 4; i++) seq_nxt[i] = OP_END;
    n_nxt = 3'd1;
    if (ok) begin
      if (in_syndrome[6]) begin
        if (m1 == 32'h38000000 || m1 == 32'h38200800 ||
            (op & 32'h3fc00000) == 32'h39000000) begin
          seq_nxt[0] = OP_MEMW1; n_nxt = 3'd2;
        end else if (m1 == 32'h38000400 || m1 == 32'h38000c00) begin
          seq_nxt[0] = OP_WB; seq_nxt[1] = OP_MEMW1; n_nxt = 3'd3;
        end else if (m2 == 32'h29000000) begin
          seq_nxt[0] = OP_MEMW1; seq_nxt[1] = OP_MEMW2; n_nxt = 3'd3;
        end else if (m2 == 32'h28800000 || m2 == 32'h29800000) begin
          seq_nxt[0] = OP_WB; seq_nxt[1] = OP_MEMW1; seq_nxt[2] = OP_MEMW2;
          n_nxt = 3'd4;
        end
      end else begin
        if (ldp_plain || ldp_wb ||
            mp == 32'h69400000 || mp == 32'h68c00000 || mp == 32'h69c00000) begin
          seq_nxt[0] = OP_LD1; seq_nxt[1] = OP_LD2;
          if (ldp_wb || (!ldp_plain && mp != 32'h69400000)) begin
            seq_nxt[2] = OP_WB; n_nxt = 3'd4;
          end else begin
            n_nxt = 3'd3;
          end
        end else if ((op & 32'h3f000000) == 32'h18000000 ||
                     m1 == 32'h38600800 || (op & 32'h3fc00000) == 32'h39400000 ||
                     m1 == 32'h38400000 ||
                     (op & 32'h3fa00c00) == 32'h38a00800 ||
                     (op & 32'h3f800000) == 32'h39800000) begin
          seq_nxt[0] = OP_LD1; n_nxt = 3'd2;
        end else if ((op & 32'h3fe00400) == 32'h38400400 ||
                     (op & 32'h3fa00400) == 32'h38800400) begin
          seq_nxt[0] = OP_LD1; seq_nxt[1] = OP_WB; n_nxt = 3'd3;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r <= in_opcode; ia_r <= in_instruction_address; far_r <= in_fault_address;
      rd1_r <= in_read_data_first; rd2_r <= in_read_data_second;
      ok_r <= ok; wr_r <= in_syndrome[6];
      seq_r <= seq_nxt; nsteps_r <= n_nxt;
      // single stores take their source before any base writeback
      st_src_r <= (in_opcode[4:0] == 5'd31 || !vld_r[in_opcode[4:0]]) ? 64'd0 :
                  regs_r[in_opcode[4:0]];
    end
  end

  assign sts.nsteps = nsteps_r;
  assign sts.is_last = ({1'b0, cmd.idx} + 3'd1) == nsteps_r;

  // result for the current step
  step_op_t    cur;
  logic [3:0]  size, ps, ls;
  logic [4:0]  rt, rn, rt2, dst;
  logic [63:0] imm9, imm7, off, v, rn_v, rt_v, rt2_v, ldv, sv;
  logic        sx_load, is_ldp, is_ldpsw, is_lit, to64, neg, is_stp;
  logic        reg_we;

  function automatic logic [63:0] rdreg(input logic [63:0] x, input logic vb);
    rdreg = vb ? x : 64'd0;
  endfunction

  always_comb begin
    cur  = seq_r[cmd.idx];
    size = 4'd1 << op_r[31:30];
    ps   = op_r[31] ? 4'd8 : 4'd4;
    ls   = op_r[30] ? 4'd8 : 4'd4;
    rt = op_r[4:0]; rn = op_r[9:5]; rt2 = op_r[14:10];
    imm9 = {{55{op_r[20]}}, op_r[20:12]};
    imm7 = {{57{op_r[21]}}, op_r[21:15]};
    is_ldp   = ((op_r & 32'h7fc00000) == 32'h29400000) ||
               ((op_r & 32'h7ec00000) == 32'h28c00000);
    is_ldpsw = !is_ldp;
    is_lit   = (op_r & 32'h3f000000) == 32'h18000000;
    is_stp   = (op_r & 32'h7fc00000) == 32'h29000000 ||
               (op_r & 32'h7fc00000) == 32'h28800000 ||
               (op_r & 32'h7fc00000) == 32'h29800000;
    sx_load  = ((op_r & 32'h3fa00c00) == 32'h38a00800) ||
               ((op_r & 32'h3f800000) == 32'h39800000) ||
               ((op_r & 32'h3fa00400) == 32'h38800400);
    to64 = !op_r[22];
    rn_v  = rdreg(regs_r[rn], vld_r[rn]);
    rt_v  = (rt == 5'd31) ? 64'd0 : rdreg(regs_r[rt], vld_r[rt]);
    rt2_v = (rt2 == 5'd31) ? 64'd0 : rdreg(regs_r[rt2], vld_r[rt2]);
    if (wr_r && (op_r & 32'h7fc00000) != 32'h29000000 &&
        ((op_r & 32'h3fe00c00) == 32'h38000400 || (op_r & 32'h3fe00c00) == 32'h38000c00))
      off = imm9;
    else if (!wr_r && !(((op_r & 32'h7fc00000) == 32'h29400000) ||
             ((op_r & 32'h7ec00000) == 32'h28c00000) ||
             ((op_r & 32'hffc00000) == 32'h69400000) ||
             ((op_r & 32'hffc00000) == 32'h68c00000) ||
             ((op_r & 32'hffc00000) == 32'h69c00000)))
      off = imm9;
    else
      off = (ps == 4'd8) ? {imm7[60:0], 3'b000} : {imm7[61:0], 2'b00};
    // single load value
    ldv = '0; neg = 1'b0;
    if (is_lit) begin
      ldv = rd1_r & bmask(ls);
      if (op_r[31]) ldv = sx32(ldv);
    end else begin
      ldv = rd1_r & bmask(size);
      if (sx_load) begin
        case (size)
          4'd1: begin neg = ldv[7];  if (neg) ldv = ldv | 64'hffffff00; end
          4'd2: begin neg = ldv[15]; if (neg) ldv = ldv | 64'hffff0000; end
          4'd4: neg = ldv[31];
          default: neg = 1'b0;
        endcase
        if (neg && to64) ldv = ldv | 64'hffffffff00000000;
      end
    end
    res_kind = KIND_REG; res_target = '0; res_size = '0; res_data = '0;
    dst = rt; v = '0; reg_we = 1'b0; sv = '0;
    case (cur)
      OP_MEMW1: begin
        res_kind = KIND_WRITE; res_target = far_r;
        sv = is_stp ? {60'd0, ps} : {60'd0, size};
        res_size = sv[3:0];
        res_data = (is_stp ? rt_v : st_src_r) & bmask(sv[3:0]);
      end
      OP_MEMW2: begin
        res_kind = KIND_WRITE; res_target = far_r + {60'd0, ps};
        res_size = ps; res_data = rt2_v & bmask(ps);
      end
      OP_LD1: begin
        dst = rt;
        if (is_ldp && !is_lit) v = rd1_r & bmask(ps);
        else if (is_ldpsw && seq_r[1] == OP_LD2) v = sx32(rd1_r & 64'hffffffff);
        else v = ldv;
        if (is_ldp && seq_r[1] == OP_LD2) v = rd1_r & bmask(ps);
        reg_we = 1'b1;
      end
      OP_LD2: begin
        dst = rt2;
        v = is_ldp ? (rd2_r & bmask(ps)) : sx32(rd2_r & 64'hffffffff);
        reg_we = 1'b1;
      end
      OP_WB: begin
        dst = rn;
        if (!wr_r && !is_ldp && (op_r & 32'hffc00000) != 32'h69400000 &&
            ((op_r & 32'hffc00000) == 32'h68c00000 ||
             (op_r & 32'hffc00000) == 32'h69c00000))
          v = rn_v + {imm7[61:0], 2'b00};
        else v = rn_v + off;
        reg_we = 1'b1;
      end
      OP_END: begin
        res_kind = ok_r ? (nsteps_r == 3'd1 ? KIND_UNH : KIND_DONE) : KIND_UNH;
        res_target = ok_r ? ia_r + 64'd4 : ia_r;
      end
      default: ;
    endcase
    if (reg_we) begin
      res_kind = KIND_REG; res_target = {59'd0, dst}; res_data = v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.slot_wr) begin
      vld_r[in_slot_index] <= 1'b1;
    end else if (cmd.step && reg_we) begin
      vld_r[dst] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.slot_wr) regs_r[in_slot_index] <= in_slot_value;
    else if (cmd.step && reg_we) regs_r[dst] <= v;
  end
endmodule
`default_nettype wire

@@ rtl/lsfr_ctrl.sv @@
// Controller: accepts items and sequences one result per step.
`default_nettype none
module lsfr_ctrl
  import lsfr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  input  wire logic  in_mode,
  output logic       in_ready,
  output logic       out_valid,
  input  wire logic  out_ready,
  input  wire lsfr_sts_t sts,
  output lsfr_cmd_t  cmd,
  output logic       out_last
);
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       acc;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);
  assign out_last  = sts.is_last;
  assign acc       = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r; idx_nxt = idx_r;
    cmd.start = acc && in_mode;
    cmd.slot_wr = acc && !in_mode;
    cmd.step = out_valid && out_ready;
    cmd.idx = idx_r;
    case (state_r)
      ST_IDLE: if (acc && in_mode) begin state_nxt = ST_EMIT; idx_nxt = '0; end
      ST_EMIT: if (out_ready) begin
        if (sts.is_last) state_nxt = ST_IDLE;
        else idx_nxt = idx_r + 2'd1;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; idx_r <= '0;
    end else begin
      state_r <= state_nxt; idx_r <= idx_nxt;
    end
  end
endmodule
`default_nettype wire

@@ rtl/load_store_fault_replay.sv @@
// Top level: load/store fault replay block.
//  channel | ports              | handshake
//  input   | in_*               | in_valid / in_ready
//  result  | out_*              | out_valid / out_ready
// A fault event is accepted and then gives one result per step (1 to 4 results).
// A slot load is written when it is accepted and gives no result.
// Reset (rst_n low, synchronous) clears the control state and the slot valid bits.
// A stalled out_ready holds the current result; no new item is taken meanwhile.
`default_nettype none
module load_store_fault_replay
  import lsfr_pkg::*;
#(
  parameter int unsigned REGISTER_SLOTS = SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_mode,
  input  wire logic [4:0]  in_slot_index,
  input  wire logic [63:0] in_slot_value,
  input  wire logic [10:0] in_vector_offset,
  input  wire logic [31:0] in_syndrome,
  input  wire logic [31:0] in_opcode,
  input  wire logic [63:0] in_instruction_address,
  input  wire logic [63:0] in_fault_address,
  input  wire logic [63:0] in_read_data_first,
  input  wire logic [63:0] in_read_data_second,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [63:0]      out_target,
  output logic [3:0]       out_access_size,
  output logic [63:0]      out_data,
  output logic             out_last
);
  lsfr_cmd_t cmd;
  lsfr_sts_t sts;

  lsfr_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_mode, .in_ready, .out_valid, .out_ready,
    .sts, .cmd, .out_last
  );

  lsfr_dp #(.SLOTS(REGISTER_SLOTS)) u_dp (
    .clk, .cmd, .in_slot_index, .in_slot_value, .in_vector_offset, .in_syndrome,
    .in_opcode, .in_instruction_address, .in_fault_address, .in_read_data_first,
    .in_read_data_second, .rst_n, .sts,
    .res_kind(out_kind), .res_target(out_target), .res_size(out_access_size),
    .res_data(out_data)
  );
endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Testbench for load_store_fault_replay: directed table, then random faults checked by predictor.
`timescale 1ns / 100ps
module tb_top;
  import lsfr_pkg::*;

  typedef struct {
    logic        mode;
    logic [4:0]  slot;
    logic [63:0] sval;
    logic [10:0] vec;
    logic [31:0] syn;
    logic [31:0] op;
    logic [63:0] ia;
    logic [63:0] far;
    logic [63:0] rd1;
    logic [63:0] rd2;
  } fault_item_t;

  typedef struct {
    logic [1:0]  kind;
    logic [63:0] target;
    logic [3:0]  size;
    logic [63:0] data;
    logic        last;
  } replay_res_t;

  localparam logic [31:0] SYN_WR = 32'h9200_0040;
  localparam logic [31:0] SYN_RD = 32'h9200_0000;
  localparam int WATCHDOG = 1500;
  localparam int N_RAND = 350;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic in_mode;
  logic [4:0] in_slot_index;
  logic [63:0] in_slot_value, in_instruction_address, in_fault_address;
  logic [63:0] in_read_data_first, in_read_data_second;
  logic [10:0] in_vector_offset;
  logic [31:0] in_syndrome, in_opcode;
  logic [1:0] out_kind;
  logic [63:0] out_target, out_data;
  logic [3:0] out_access_size;
  logic out_last;

  load_store_fault_replay u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_mode(in_mode), .in_slot_index(in_slot_index), .in_slot_value(in_slot_value),
    .in_vector_offset(in_vector_offset), .in_syndrome(in_syndrome), .in_opcode(in_opcode),
    .in_instruction_address(in_instruction_address), .in_fault_address(in_fault_address),
    .in_read_data_first(in_read_data_first), .in_read_data_second(in_read_data_second),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_kind(out_kind), .out_target(out_target), .out_access_size(out_access_size),
    .out_data(out_data), .out_last(out_last)
  );

  logic [63:0] ctx_regs [32];
  replay_res_t exp_q[$];
  int errors = 0;
  int in_xfers = 0;
  int out_xfers = 0;
  int quiet_cycles = 0;
  bit no_idle = 0;
  int long_hold = 0;
  bit cur_typed = 0;
  replay_res_t cur_exp;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // ---------------- predictor ----------------
  function automatic logic [63:0] bmask(int unsigned n);
    return (n >= 8) ? '1 : ((64'd1 << (n * 8)) - 64'd1);
  endfunction

  function automatic void push_res(logic [1:0] k, logic [63:0] t, logic [3:0] s,
                                   logic [63:0] d);
    replay_res_t r;
    r.kind = k; r.target = t; r.size = s; r.data = d; r.last = 1'b0;
    exp_q.push_back(r);
  endfunction

  function automatic void set_slot(logic [4:0] r, logic [63:0] v);
    ctx_regs[r] = v;
    push_res(KIND_REG, {59'd0, r}, 4'd0, v);
  endfunction

  function automatic void add_base(logic [4:0] r, logic [63:0] off);
    set_slot(r, ctx_regs[r] + off);
  endfunction

  function automatic logic [63:0] store_src(logic [4:0] r);
    return (r == 5'd31) ? 64'd0 : ctx_regs[r];
  endfunction

  function automatic logic [63:0] sx32(logic [63:0] v);
    return v[31] ? (v | 64'hFFFF_FFFF_0000_0000) : v;
  endfunction

  function automatic logic [63:0] sign_fill(logic [63:0] v, int unsigned sz, bit to64);
    bit neg;
    neg = 0;
    if (sz == 1) begin
      neg = v[7];
      if (neg) v[31:8] = '1;
    end else if (sz == 2) begin
      neg = v[15];
      if (neg) v[31:16] = '1;
    end else if (sz == 4) begin
      neg = v[31];
    end
    if (neg && to64) v[63:32] = '1;
    return v;
  endfunction

  function automatic void replay_fault(fault_item_t it);
    logic [31:0] op, m1, m2, mp;
    logic [4:0] rt, rn, rt2;
    logic [63:0] i9, i7, v;
    int unsigned sz, ps;
    bit done, ldp_plain, ldp_wb;
    if (!it.mode) begin
      ctx_regs[it.slot] = it.sval;
      return;
    end
    if (it.vec[8:0] != 0 || (it.syn & 32'hF800_0000) != 32'h9000_0000) begin
      push_res(KIND_UNH, it.ia, 4'd0, 64'd0);
      exp_q[$].last = 1'b1;
      return;
    end
    op = it.op;
    sz = 1 << op[31:30];
    rt = op[4:0]; rn = op[9:5]; rt2 = op[14:10];
    i9 = {{55{op[20]}}, op[20:12]};
    i7 = {{57{op[21]}}, op[21:15]};
    m1 = op & 32'h3FE0_0C00;
    done = 0;
    if (it.syn[6]) begin
      m2 = op & 32'h7FC0_0000;
      if (m1 == 32'h3800_0000 || m1 == 32'h3820_0800 || (op & 32'h3FC0_0000) == 32'h3900_0000) begin
        push_res(KIND_WRITE, it.far, 4'(sz), store_src(rt) & bmask(sz));
        done = 1;
      end else if (m1 == 32'h3800_0400 || m1 == 32'h3800_0C00) begin
        v = store_src(rt);
        add_base(rn, i9);
        push_res(KIND_WRITE, it.far, 4'(sz), v & bmask(sz));
        done = 1;
      end else if (m2 == 32'h2900_0000 || m2 == 32'h2880_0000 || m2 == 32'h2980_0000) begin
        ps = op[31] ? 8 : 4;
        if (m2 != 32'h2900_0000) add_base(rn, i7 * ps);
        push_res(KIND_WRITE, it.far, 4'(ps), store_src(rt) & bmask(ps));
        push_res(KIND_WRITE, it.far + ps, 4'(ps), store_src(rt2) & bmask(ps));
        done = 1;
      end
    end else begin
      mp = op & 32'hFFC0_0000;
      ldp_plain = (op & 32'h7FC0_0000) == 32'h2940_0000;
      ldp_wb = (op & 32'h7EC0_0000) == 32'h28C0_0000;
      if (ldp_plain || ldp_wb) begin
        ps = op[31] ? 8 : 4;
        set_slot(rt, it.rd1 & bmask(ps));
        set_slot(rt2, it.rd2 & bmask(ps));
        if (ldp_wb) add_base(rn, i7 * ps);
        done = 1;
      end else if (mp == 32'h6940_0000 || mp == 32'h68C0_0000 || mp == 32'h69C0_0000) begin
        set_slot(rt, sx32(it.rd1 & 64'hFFFF_FFFF));
        set_slot(rt2, sx32(it.rd2 & 64'hFFFF_FFFF));
        if (mp != 32'h6940_0000) add_base(rn, i7 * 4);
        done = 1;
      end else if ((op & 32'h3F00_0000) == 32'h1800_0000) begin
        v = it.rd1 & bmask(op[30] ? 8 : 4);
        if (op[31]) v = sx32(v);
        set_slot(rt, v);
        done = 1;
      end else if (m1 == 32'h3860_0800 || (op & 32'h3FC0_0000) == 32'h3940_0000 ||
                   m1 == 32'h3840_0000) begin
        set_slot(rt, it.rd1 & bmask(sz));
        done = 1;
      end else if ((op & 32'h3FE0_0400) == 32'h3840_0400) begin
        set_slot(rt, it.rd1 & bmask(sz));
        add_base(rn, i9);
        done = 1;
      end else if ((op & 32'h3FA0_0C00) == 32'h38A0_0800 ||
                   (op & 32'h3F80_0000) == 32'h3980_0000 ||
                   (op & 32'h3FA0_0400) == 32'h3880_0400) begin
        set_slot(rt, sign_fill(it.rd1 & bmask(sz), sz, !op[22]));
        if ((op & 32'h3FA0_0400) == 32'h3880_0400) add_base(rn, i9);
        done = 1;
      end
    end
    push_res(done ? KIND_DONE : KIND_UNH, it.ia + 64'd4, 4'd0, 64'd0);
    exp_q[$].last = 1'b1;
  endfunction

  // ---------------- monitors ----------------
  always @(posedge clk) begin
    fault_item_t it;
    replay_res_t e;
    if (rst_n && in_valid && in_ready) begin
      it.mode = in_mode; it.slot = in_slot_index; it.sval = in_slot_value;
      it.vec = in_vector_offset; it.syn = in_syndrome; it.op = in_opcode;
      it.ia = in_instruction_address; it.far = in_fault_address;
      it.rd1 = in_read_data_first; it.rd2 = in_read_data_second;
      if (cur_typed) exp_q.push_back(cur_exp);
      else replay_fault(it);
      in_xfers++;
    end
    if (rst_n && out_valid && out_ready) begin
      out_xfers++;
      if (exp_q.size() == 0) begin
        $display("%0t: unexpected result kind=%0d target=%h", $time, out_kind, out_target);
        errors++;
      end else begin
        e = exp_q.pop_front();
        if (out_kind !== e.kind || out_target !== e.target || out_access_size !== e.size ||
            out_data !== e.data || out_last !== e.last) begin
          $display("%0t: mismatch exp kind=%0d target=%h size=%0d data=%h last=%0d",
                   $time, e.kind, e.target, e.size, e.data, e.last);
          $display("%0t:          act kind=%0d target=%h size=%0d data=%h last=%0d",
                   $time, out_kind, out_target, out_access_size, out_data, out_last);
          errors++;
        end
      end
    end
    if (rst_n && !(in_valid && in_ready) && !(out_valid && out_ready)) quiet_cycles++;
    else quiet_cycles = 0;
    if (quiet_cycles >= WATCHDOG) begin
      $display("%0t: watchdog, no transfer for %0d cycles", $time, WATCHDOG);
      $display("FAIL load_store_fault_replay");
      $finish;
    end
  end

  // ---------------- receiver ----------------
  initial begin
    int w, seen;
    out_ready = 0;
    @(posedge rst_n);
    forever begin
      w = no_idle ? 0 : $urandom_range(0, 8);
      if (long_hold > 0) begin
        w = long_hold;
        long_hold = 0;
      end
      if (w > 0) begin
        out_ready = 0;
        repeat (w) @(negedge clk);
      end
      out_ready = 1;
      seen = out_xfers;
      do @(negedge clk); while (out_xfers == seen);
    end
  end

  // ---------------- stimulus ----------------
  function automatic fault_item_t ld(logic [4:0] s, logic [63:0] v);
    fault_item_t it;
    it = '{default: '0};
    it.mode = 0; it.slot = s; it.sval = v;
    return it;
  endfunction

  function automatic fault_item_t ev(logic [10:0] vec, logic [31:0] syn, logic [31:0] op,
                                     logic [63:0] ia, logic [63:0] far,
                                     logic [63:0] rd1, logic [63:0] rd2);
    fault_item_t it;
    it = '{default: '0};
    it.mode = 1; it.vec = vec; it.syn = syn; it.op = op; it.ia = ia; it.far = far;
    it.rd1 = rd1; it.rd2 = rd2;
    return it;
  endfunction

  task automatic drive(fault_item_t it);
    int g, seen;
    g = no_idle ? 0 : $urandom_range(0, 8);
    if (g > 0) begin
      in_valid = 0;
      repeat (g) @(negedge clk);
    end
    in_mode = it.mode; in_slot_index = it.slot; in_slot_value = it.sval;
    in_vector_offset = it.vec; in_syndrome = it.syn; in_opcode = it.op;
    in_instruction_address = it.ia; in_fault_address = it.far;
    in_read_data_first = it.rd1; in_read_data_second = it.rd2;
    in_valid = 1;
    seen = in_xfers;
    do @(negedge clk); while (in_xfers == seen);
  endtask

  // opcode shapes for well-formed faults: fixed bits and free bits; the first eight are stores
  logic [31:0] shape_base [24] = '{
    32'h3900_0000, 32'h3800_0000, 32'h3820_0800, 32'h3800_0400, 32'h3800_0C00,
    32'h2900_0000, 32'h2880_0000, 32'h2980_0000,
    32'h2940_0000, 32'h28C0_0000, 32'h29C0_0000, 32'h6940_0000, 32'h68C0_0000,
    32'h69C0_0000, 32'h1800_0000, 32'h3940_0000, 32'h3840_0000, 32'h3860_0800,
    32'h3840_0400, 32'h3840_0C00, 32'h3980_0000, 32'h3880_0400, 32'h3880_0C00,
    32'h38A0_0800};
  logic [31:0] shape_free [24] = '{
    32'hC03F_FFFF, 32'hC01F_F3FF, 32'hC01F_F3FF, 32'hC01F_F3FF, 32'hC01F_F3FF,
    32'h803F_FFFF, 32'h803F_FFFF, 32'h803F_FFFF,
    32'h803F_FFFF, 32'h803F_FFFF, 32'h803F_FFFF, 32'h003F_FFFF, 32'h003F_FFFF,
    32'h003F_FFFF, 32'hC0FF_FFFF, 32'hC03F_FFFF, 32'hC01F_F3FF, 32'hC01F_F3FF,
    32'hC01F_F3FF, 32'hC01F_F3FF, 32'hC07F_FFFF, 32'hC05F_FBFF, 32'hC05F_FBFF,
    32'hC05F_F3FF};

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  initial begin
    fault_item_t dir_tbl[$];
    bit typed_tbl[$];
    fault_item_t it;
    int k, pick, sel;
    logic [63:0] top;

    in_valid = 0; in_mode = 0; in_slot_index = 0; in_slot_value = 0;
    in_vector_offset = 0; in_syndrome = 0; in_opcode = 0; in_instruction_address = 0;
    in_fault_address = 0; in_read_data_first = 0; in_read_data_second = 0;
    for (k = 0; k < 32; k++) ctx_regs[k] = 64'd0;
    rst_n = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    top = '1;
    // rejects and unknown words carry a hand-written expectation
    dir_tbl.push_back(ev(11'h001, SYN_WR, 32'hF900_0040, 64'h1000, 0, 0, 0));
    typed_tbl.push_back(1);
    dir_tbl.push_back(ev(11'h200, 32'h9800_0040, 32'hF900_0040, top, 0, 0, 0));
    typed_tbl.push_back(1);
    dir_tbl.push_back(ev(11'h000, SYN_WR, 32'h0000_0000, 64'h2000, 0, 0, 0));
    typed_tbl.push_back(1);
    dir_tbl.push_back(ev(11'h600, SYN_RD, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFC, 0, 0, 0));
    typed_tbl.push_back(1);
    // untouched slots read as zero after reset
    dir_tbl.push_back(ev(11'h400, SYN_WR, 32'hF900_0040, 64'h10, top, 0, 0));
    dir_tbl.push_back(ld(5'd0, top));
    dir_tbl.push_back(ld(5'd1, 64'h8000_0000_0000_0080));
    dir_tbl.push_back(ld(5'd2, 64'h1000));
    dir_tbl.push_back(ld(5'd31, 64'h5555_5555_5555_5555));
    dir_tbl.push_back(ev(11'h400, SYN_WR, 32'hF900_0040, 64'h10, top, 0, 0));
    dir_tbl.push_back(ev(11'h000, SYN_WR, 32'h3900_005F, 64'h20, 64'h40, 0, 0));
    dir_tbl.push_back(ev(11'h000, SYN_WR, 32'hF810_0441, 64'h30, 64'h80, 0, 0));
    dir_tbl.push_back(ev(11'h000, SYN_WR, 32'hF80F_FC41, 64'h40, 64'h90, 0, 0));
    dir_tbl.push_back(ev(11'h000, SYN_WR, 32'hA9A0_0440, 64'h50, 64'hFFFF_FFFF_FFFF_FFF8, 0, 0));
    dir_tbl.push_back(ev(11'h000, SYN_WR, 32'h289F_FC41, 64'h60, 64'h100, 0, 0));
    dir_tbl.push_back(ev(11'h000, SYN_RD, 32'hA940_10A3, 64'h70, 0, top, 64'h1234));
    dir_tbl.push_back(ev(11'h000, SYN_RD, 32'h28C0_9842, 64'h80, 0, top, top));
    dir_tbl.push_back(ev(11'h000, SYN_RD, 32'h68C1_2127, 64'h90, 0,
                         64'h8000_0000, 64'h7FFF_FFFF));
    dir_tbl.push_back(ev(11'h000, SYN_RD, 32'h9800_0003, 64'hA0, 0, 64'hFFFF_FFFF, 0));
    dir_tbl.push_back(ev(11'h000, SYN_RD, 32'h3940_0003, 64'hB0, 0, top, 0));
    dir_tbl.push_back(ev(11'h000, SYN_RD, 32'h3980_0003, 64'hC0, 0, 64'h80, 0));
    dir_tbl.push_back(ev(11'h000, SYN_RD, 32'h79C0_0003, 64'hD0, 0, 64'h8000, 0));
    dir_tbl.push_back(ev(11'h000, SYN_RD, 32'hB880_14A5, 64'hE0, 0, 64'hFFFF_FFFF, 0));
    dir_tbl.push_back(ev(11'h000, SYN_RD, 32'hF85F_FCA6, 64'hF0, 0, top, 0));
    dir_tbl.push_back(ev(11'h000, SYN_RD, 32'hF860_0807, top, 0, top, 0));

    for (k = 0; k < dir_tbl.size(); k++) begin
      it = dir_tbl[k];
      cur_typed = typed_tbl.size() > k ? typed_tbl[k] : 1'b0;
      if (cur_typed) begin
        cur_exp.kind = KIND_UNH;
        cur_exp.target = (k < 2) ? it.ia : it.ia + 64'd4;
        cur_exp.size = 4'd0; cur_exp.data = 64'd0; cur_exp.last = 1'b1;
      end
      drive(it);
    end
    cur_typed = 0;

    for (k = 0; k < N_RAND; k++) begin
      no_idle = (k >= 100 && k < 140);
      if (k == 200) long_hold = 300;
      if (k == 300) begin
        // let the block drain before going on
        in_valid = 0;
        while (exp_q.size() != 0) @(negedge clk);
      end
      sel = $urandom_range(0, 99);
      if (sel < 20) begin
        it = ld(5'($urandom_range(0, 31)), rnd64());
      end else if (sel < 35) begin
        it = ev(11'($urandom), $urandom, $urandom, rnd64(), rnd64(), rnd64(), rnd64());
        if ($urandom_range(0, 1)) it.syn[31:27] = 5'b10010;
      end else begin
        pick = $urandom_range(0, 23);
        it = ev({2'($urandom_range(0, 3)), 9'd0}, 32'h9000_0000 | ($urandom & 32'h07FF_FFBF),
                shape_base[pick] | ($urandom & shape_free[pick]),
                rnd64(), rnd64(), rnd64(), rnd64());
        it.syn[6] = (pick < 8);
        if ($urandom_range(0, 3) == 0) it.far = top - $urandom_range(0, 15);
      end
      drive(it);
    end
    in_valid = 0;

    while (exp_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0 && exp_q.size() == 0) begin
      $display("PASS load_store_fault_replay");
    end else begin
      $display("FAIL load_store_fault_replay");
    end
    $finish;
  end
endmodule
